/* design/lp2r_pkg.sv */
// Shared types, widths, register codes and the square-root step for the lidar range pixel block.
package lp2r_pkg;

	// Field and datapath widths.
	localparam int COORD_W         = 24;
	localparam int MAG_W           = 24;
	localparam int SUM_W           = 2 * MAG_W;
	localparam int ROOT_W          = SUM_W / 2;
	localparam int REM_W           = ROOT_W + 1;
	localparam int STR_W           = 16;
	localparam int PIX_W           = 8;
	localparam int SCALE_W         = 8;
	localparam int MINR_W          = 23;
	localparam int PROD_W          = ROOT_W + SCALE_W;
	localparam int DATA_W          = 32;
	localparam int ADDR_W          = 3;

	// Square-root pipeline shape: two result bits per stage.
	localparam int STEPS_PER_STAGE = 2;
	localparam int SQRT_STAGES     = ROOT_W / STEPS_PER_STAGE;

	localparam logic [PIX_W-1:0]   PIX_MAX         = 8'hFF;
	localparam logic [SCALE_W-1:0] RANGE_SCALE_RST = 8'd20;
	localparam logic [MINR_W-1:0]  MIN_RANGE_RST   = 23'd102;

	// Register select, taken from the word address bit.
	localparam logic REG_RANGE_SCALE = 1'b0;
	localparam logic REG_MIN_RANGE   = 1'b1;

	// Per-point data that travels alongside the range computation.
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [PIX_W-1:0]          strength;
		logic [PIX_W-1:0]          ambient;
	} side_t;

	typedef struct packed {
		side_t            side;
		logic [SUM_W-1:0] sum;
	} sum_word_t;

	typedef struct packed {
		side_t             side;
		logic [ROOT_W-1:0] root;
	} root_word_t;

	typedef struct packed {
		logic [PIX_W-1:0]          range_pixel;
		logic [PIX_W-1:0]          strength_pixel;
		logic [PIX_W-1:0]          ambient_pixel;
		logic                      point_kept;
		logic signed [COORD_W-1:0] kept_x;
		logic signed [COORD_W-1:0] kept_y;
		logic signed [COORD_W-1:0] kept_z;
		logic [PIX_W-1:0]          kept_strength;
	} pix_word_t;

	// Working state of the digit-by-digit square root.
	typedef struct packed {
		logic [SUM_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_state_t;

	// One result bit: bring down two radicand bits and try a one.
	function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
		logic [REM_W+1:0] acc;
		logic [REM_W+1:0] trial;
		logic [REM_W+1:0] diff;
		sqrt_state_t      n;
		acc   = {s.rem, s.rad[SUM_W-1 -: 2]};
		trial = {1'b0, s.root, 2'b01};
		diff  = acc - trial;
		n.rad = {s.rad[SUM_W-3:0], 2'b00};
		if (acc >= trial) begin
			n.rem  = diff[REM_W-1:0];
			n.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			n.rem  = acc[REM_W-1:0];
			n.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return n;
	endfunction

endpackage

/* design/lp2r_square.sv */
// Front stages: coordinate magnitudes, squares and the sum of squares.
module lp2r_square
	import lp2r_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_z,
	input  logic [STR_W-1:0]          return_strength,
	input  logic [PIX_W-1:0]          ambient_level,
	output logic                      out_valid,
	output sum_word_t                 out_word
);

	logic             vld_s1, vld_s2, vld_s3;
	logic [MAG_W-1:0] mag_x_s1, mag_y_s1, mag_z_s1;
	logic [SUM_W-1:0] sq_x_s2, sq_y_s2, sq_z_s2;
	side_t            side_s1, side_s2, side_s3;
	logic [SUM_W-1:0] sum_s3;
	side_t            side_in;

	// Clamp the strength now so that only eight bits travel down the pipe.
	always_comb begin
		side_in.x        = coord_x;
		side_in.y        = coord_y;
		side_in.z        = coord_z;
		side_in.strength = (|return_strength[STR_W-1:PIX_W]) ? PIX_MAX
			: return_strength[PIX_W-1:0];
		side_in.ambient  = ambient_level;
	end

	// Valid bits advance with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Magnitudes, then squares, then the three-way sum.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_x_s1 <= coord_x[COORD_W-1] ? MAG_W'(-coord_x) : MAG_W'(coord_x);
			mag_y_s1 <= coord_y[COORD_W-1] ? MAG_W'(-coord_y) : MAG_W'(coord_y);
			mag_z_s1 <= coord_z[COORD_W-1] ? MAG_W'(-coord_z) : MAG_W'(coord_z);
			side_s1  <= side_in;

			sq_x_s2  <= SUM_W'(mag_x_s1) * SUM_W'(mag_x_s1);
			sq_y_s2  <= SUM_W'(mag_y_s1) * SUM_W'(mag_y_s1);
			sq_z_s2  <= SUM_W'(mag_z_s1) * SUM_W'(mag_z_s1);
			side_s2  <= side_s1;

			sum_s3   <= sq_x_s2 + sq_y_s2 + sq_z_s2;
			side_s3  <= side_s2;
		end
	end

	assign out_valid     = vld_s3;
	assign out_word.side = side_s3;
	assign out_word.sum  = sum_s3;

endmodule

/* design/lp2r_sqrt.sv */
// Pipelined floor square root, two result bits per register stage.
module lp2r_sqrt
	import lp2r_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  sum_word_t  in_word,
	output logic       out_valid,
	output root_word_t out_word
);

	logic        vld_s   [SQRT_STAGES];
	side_t       side_s  [SQRT_STAGES];
	sqrt_state_t sqrt_s  [SQRT_STAGES];
	sqrt_state_t stage_in[SQRT_STAGES];
	logic        vld_in  [SQRT_STAGES];
	side_t       side_in [SQRT_STAGES];

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
		sqrt_state_t nxt_state;

		// Stage input: the fresh sum at the head, the previous stage elsewhere.
		if (g == 0) begin : g_head
			assign stage_in[g].rad  = in_word.sum;
			assign stage_in[g].rem  = '0;
			assign stage_in[g].root = '0;
			assign vld_in[g]        = in_valid;
			assign side_in[g]       = in_word.side;
		end else begin : g_body
			assign stage_in[g] = sqrt_s[g-1];
			assign vld_in[g]   = vld_s[g-1];
			assign side_in[g]  = side_s[g-1];
		end

		// Two dependent root digits per stage.
		always_comb begin
			nxt_state = stage_in[g];
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				nxt_state = sqrt_step(nxt_state);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqrt_s[g] <= nxt_state;
				side_s[g] <= side_in[g];
			end
		end
	end

	assign out_valid     = vld_s[SQRT_STAGES-1];
	assign out_word.side = side_s[SQRT_STAGES-1];
	assign out_word.root = sqrt_s[SQRT_STAGES-1].root;

endmodule

/* design/lp2r_pixel.sv */
// Pixel stage: scaling, saturation and the range test, followed by the output skid buffer.
module lp2r_pixel
	import lp2r_pkg::*;
#(
	parameter int FRAC_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  root_word_t         in_word,
	input  logic [SCALE_W-1:0] range_scale,
	input  logic [MINR_W-1:0]  min_range,
	output logic               en,
	output logic               out_valid,
	input  logic               out_ready,
	output pix_word_t          out_word
);

	logic              res_vld_s;
	pix_word_t         res_s;
	pix_word_t         res_nxt;
	logic              skid_vld_q;
	pix_word_t         skid_q;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_int;
	logic              kept;

	// The pipe moves whenever the skid buffer is free.
	assign en = !skid_vld_q;

	// Scale the range, drop the fraction, saturate and decide whether to keep.
	always_comb begin
		prod     = PROD_W'(in_word.root) * PROD_W'(range_scale);
		prod_int = prod >> FRAC_BITS;
		kept     = in_word.root >= ROOT_W'(min_range);

		res_nxt.range_pixel    = (|prod_int[PROD_W-1:PIX_W]) ? PIX_MAX : prod_int[PIX_W-1:0];
		res_nxt.strength_pixel = in_word.side.strength;
		res_nxt.ambient_pixel  = in_word.side.ambient;
		res_nxt.point_kept     = kept;
		res_nxt.kept_x         = kept ? in_word.side.x : '0;
		res_nxt.kept_y         = kept ? in_word.side.y : '0;
		res_nxt.kept_z         = kept ? in_word.side.z : '0;
		res_nxt.kept_strength  = kept ? in_word.side.strength : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s <= 1'b0;
		end else if (en) begin
			res_vld_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s <= res_nxt;
		end
	end

	// A word that is not taken while the pipe moves is parked in the skid buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en && res_vld_s && !out_ready) begin
			skid_vld_q <= 1'b1;
		end else if (skid_vld_q && out_ready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_vld_s && !out_ready) begin
			skid_q <= res_s;
		end
	end

	assign out_valid = skid_vld_q || res_vld_s;
	assign out_word  = skid_vld_q ? skid_q : res_s;

endmodule

/* design/lidar_point_to_range_pixel.sv */
// Top level of the lidar point to range pixel block: register port and pipeline.
//
// One lidar point enters on the point channel (point_valid / point_ready) and
// one pixel word leaves on the pixel channel (pixel_valid / pixel_ready).
// A word is taken at a rising edge at which valid and ready are both high.
// The pipeline takes a new point in every cycle, so a stream of points runs
// at one point per cycle while the receiver keeps pixel_ready high.
// From acceptance to pixel_valid a point passes three stages for the
// magnitudes, squares and sum of squares, twelve for the square root (two
// result bits per stage) and one for scaling and the range test.
// When the receiver stalls, the waiting word is parked in a one-word skid
// buffer and the whole pipe holds; point_ready falls in the next cycle and
// rises again once that word has gone. No word is lost or repeated.
// range_scale (address 0) and min_range (address 4) are written over the
// APB-style port, which never inserts wait states; write them only while the
// pipe is empty. Reset clears every valid bit and loads range_scale with 20
// and min_range with 102.
module lidar_point_to_range_pixel
	import lp2r_pkg::*;
#(
	parameter int FRAC_BITS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,

	input  logic                      point_valid,
	output logic                      point_ready,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_z,
	input  logic [STR_W-1:0]          return_strength,
	input  logic [PIX_W-1:0]          ambient_level,

	output logic                      pixel_valid,
	input  logic                      pixel_ready,
	output logic [PIX_W-1:0]          range_pixel,
	output logic [PIX_W-1:0]          strength_pixel,
	output logic [PIX_W-1:0]          ambient_pixel,
	output logic                      point_kept,
	output logic signed [COORD_W-1:0] kept_x,
	output logic signed [COORD_W-1:0] kept_y,
	output logic signed [COORD_W-1:0] kept_z,
	output logic [PIX_W-1:0]          kept_strength
);

	logic [SCALE_W-1:0] scale_q;
	logic [MINR_W-1:0]  min_range_q;
	logic               en;
	logic               sum_vld;
	sum_word_t          sum_word;
	logic               root_vld;
	root_word_t         root_word;
	pix_word_t          pix_word;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= RANGE_SCALE_RST;
			min_range_q <= MIN_RANGE_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_RANGE_SCALE: scale_q     <= pwdata[SCALE_W-1:0];
				REG_MIN_RANGE:   min_range_q <= pwdata[MINR_W-1:0];
				default:         scale_q     <= scale_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[2])
			REG_RANGE_SCALE: prdata = DATA_W'(scale_q);
			REG_MIN_RANGE:   prdata = DATA_W'(min_range_q);
			default:         prdata = '0;
		endcase
	end

	assign point_ready = en;

	lp2r_square u_square (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (point_valid),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.coord_z         (coord_z),
		.return_strength (return_strength),
		.ambient_level   (ambient_level),
		.out_valid       (sum_vld),
		.out_word        (sum_word)
	);

	lp2r_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sum_vld),
		.in_word   (sum_word),
		.out_valid (root_vld),
		.out_word  (root_word)
	);

	lp2r_pixel #(
		.FRAC_BITS (FRAC_BITS)
	) u_pixel (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (root_vld),
		.in_word     (root_word),
		.range_scale (scale_q),
		.min_range   (min_range_q),
		.en          (en),
		.out_valid   (pixel_valid),
		.out_ready   (pixel_ready),
		.out_word    (pix_word)
	);

	assign range_pixel    = pix_word.range_pixel;
	assign strength_pixel = pix_word.strength_pixel;
	assign ambient_pixel  = pix_word.ambient_pixel;
	assign point_kept     = pix_word.point_kept;
	assign kept_x         = pix_word.kept_x;
	assign kept_y         = pix_word.kept_y;
	assign kept_z         = pix_word.kept_z;
	assign kept_strength  = pix_word.kept_strength;

endmodule

/* design/lp2r_checker.sv */
// Port-level checks for the lidar range pixel block, bound to the top level.
module lp2r_checker
	import lp2r_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      point_ready,
	input logic                      pixel_valid,
	input logic                      pixel_ready,
	input logic [PIX_W-1:0]          range_pixel,
	input logic [PIX_W-1:0]          strength_pixel,
	input logic                      point_kept,
	input logic signed [COORD_W-1:0] kept_x,
	input logic signed [COORD_W-1:0] kept_y,
	input logic signed [COORD_W-1:0] kept_z,
	input logic [PIX_W-1:0]          kept_strength
);

	// The input side only stalls when a finished word is waiting at the output.
	a_stall_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		!point_ready |-> pixel_valid)
		else $error("point channel stalled with no pixel word waiting");

	// A refused word is held, unchanged, into the next cycle.
	a_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=>
			pixel_valid && $stable(range_pixel) && $stable(point_kept) && $stable(kept_x))
		else $error("pixel word dropped or changed while stalled");

	// A rejected point carries no coordinates and no strength.
	a_drop_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !point_kept |->
			kept_x == '0 && kept_y == '0 && kept_z == '0 && kept_strength == '0)
		else $error("rejected point not zeroed");

	// A kept point carries the same strength as the strength pixel.
	a_keep_strength: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && point_kept |-> kept_strength == strength_pixel)
		else $error("kept strength differs from strength pixel");

endmodule

bind lidar_point_to_range_pixel lp2r_checker u_lp2r_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.point_ready    (point_ready),
	.pixel_valid    (pixel_valid),
	.pixel_ready    (pixel_ready),
	.range_pixel    (range_pixel),
	.strength_pixel (strength_pixel),
	.point_kept     (point_kept),
	.kept_x         (kept_x),
	.kept_y         (kept_y),
	.kept_z         (kept_z),
	.kept_strength  (kept_strength)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the lidar point to range pixel block.
`timescale 1ns / 1ps

module testbench
	import lp2r_pkg::*;
();

	localparam int FRAC_BITS   = 10;
	localparam int LATENCY     = 16;
	localparam int SETTLE      = LATENCY + 4;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 310;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [STR_W-1:0]          strength;
		logic [PIX_W-1:0]          ambient;
		int unsigned               gap;
		bit                        drain_first;
	} point_item_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ADDR_W-1:0]         paddr = '0;
	logic [DATA_W-1:0]         pwdata = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;
	logic                      point_valid = 1'b0;
	logic                      point_ready;
	logic signed [COORD_W-1:0] coord_x = '0;
	logic signed [COORD_W-1:0] coord_y = '0;
	logic signed [COORD_W-1:0] coord_z = '0;
	logic [STR_W-1:0]          return_strength = '0;
	logic [PIX_W-1:0]          ambient_level = '0;
	logic                      pixel_valid;
	logic                      pixel_ready = 1'b0;
	logic [PIX_W-1:0]          range_pixel;
	logic [PIX_W-1:0]          strength_pixel;
	logic [PIX_W-1:0]          ambient_pixel;
	logic                      point_kept;
	logic signed [COORD_W-1:0] kept_x;
	logic signed [COORD_W-1:0] kept_y;
	logic signed [COORD_W-1:0] kept_z;
	logic [PIX_W-1:0]          kept_strength;

	// Register copies used for prediction.
	logic [SCALE_W-1:0] scale_setting = RANGE_SCALE_RST;
	logic [MINR_W-1:0]  min_range_setting = MIN_RANGE_RST;

	point_item_t pending_points[$];
	pix_word_t   predicted_pixels[$];
	pix_word_t   observed_pixel;
	point_item_t next_point;

	int          points_taken = 0;
	int          pixels_taken = 0;
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          offering = 1'b0;
	int unsigned gap_waited = 0;
	int unsigned send_calm_left = 0;
	int unsigned rx_calm_left = 0;
	int unsigned rx_wait = 0;
	int unsigned hold_left = 0;
	int          hold_requests = 0;
	int          hold_served = 0;

	lidar_point_to_range_pixel #(
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.return_strength(return_strength),
		.ambient_level(ambient_level),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.range_pixel(range_pixel),
		.strength_pixel(strength_pixel),
		.ambient_pixel(ambient_pixel),
		.point_kept(point_kept),
		.kept_x(kept_x),
		.kept_y(kept_y),
		.kept_z(kept_z),
		.kept_strength(kept_strength)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Works out the pixel word that one point should give under the current settings.
	function automatic pix_word_t project_point(
		input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y,
		input logic signed [COORD_W-1:0] z,
		input logic [STR_W-1:0]          strength,
		input logic [PIX_W-1:0]          ambient,
		input logic [SCALE_W-1:0]        scale,
		input logic [MINR_W-1:0]         min_r
	);
		longint    sx;
		longint    sy;
		longint    sz;
		longint    sq_sum;
		longint    root;
		longint    cand;
		longint    scaled;
		bit        kept;
		pix_word_t w;
		sx = x;
		sy = y;
		sz = z;
		sq_sum = sx * sx + sy * sy + sz * sz;
		// Build the floor square root one bit at a time from the top.
		root = 0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			cand = root | (64'sd1 << b);
			if (cand * cand <= sq_sum)
				root = cand;
		end
		scaled = (root * longint'(scale)) >>> FRAC_BITS;
		kept = root >= longint'(min_r);
		w.range_pixel    = (scaled > 255) ? PIX_MAX : scaled[PIX_W-1:0];
		w.strength_pixel = (strength > 16'd255) ? PIX_MAX : strength[PIX_W-1:0];
		w.ambient_pixel  = ambient;
		w.point_kept     = kept;
		w.kept_x         = kept ? x : '0;
		w.kept_y         = kept ? y : '0;
		w.kept_z         = kept ? z : '0;
		w.kept_strength  = kept ? w.strength_pixel : '0;
		return w;
	endfunction

	function automatic string pixel_text(input pix_word_t w);
		return $sformatf("range=%0d strength=%0d ambient=%0d kept=%0d x=%0d y=%0d z=%0d ks=%0d",
			w.range_pixel, w.strength_pixel, w.ambient_pixel, w.point_kept,
			w.kept_x, w.kept_y, w.kept_z, w.kept_strength);
	endfunction

	// Sender gaps: usually short and random, with occasional stretches of none.
	function automatic int unsigned draw_gap();
		if (send_calm_left > 0) begin
			send_calm_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0)
			send_calm_left = $urandom_range(20, 60);
		return $urandom_range(0, 4);
	endfunction

	// Coordinates of varied magnitude, so that short ranges near the minimum are common.
	function automatic logic signed [COORD_W-1:0] random_coord();
		int k;
		int t;
		int unsigned pick;
		pick = $urandom_range(0, 39);
		if (pick == 0)
			return 24'h800000;
		if (pick == 1)
			return 24'h7FFFFF;
		k = $urandom_range(1, COORD_W);
		t = $urandom;
		t = (t <<< (32 - k)) >>> (32 - k);
		return t[COORD_W-1:0];
	endfunction

	task automatic add_point(
		input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y,
		input logic signed [COORD_W-1:0] z,
		input logic [STR_W-1:0]          strength,
		input logic [PIX_W-1:0]          ambient,
		input bit                        drain_first
	);
		point_item_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		p.strength = strength;
		p.ambient = ambient;
		p.gap = draw_gap();
		p.drain_first = drain_first;
		pending_points.push_back(p);
	endtask

	task automatic add_random_points(input int count, input int drain_at);
		logic [STR_W-1:0] s;
		for (int i = 0; i < count; i++) begin
			s = ($urandom_range(0, 2) == 0) ? STR_W'($urandom_range(0, 300)) : STR_W'($urandom);
			add_point(random_coord(), random_coord(), random_coord(), s,
				PIX_W'($urandom), i == drain_at);
		end
	endtask

	// Waits until every point has been sent and every pixel word has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_points.size() != 0 || point_valid || points_taken != pixels_taken);
	endtask

	task automatic write_reg(input logic reg_sel, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Reconfigures the block once the pipe has emptied.
	task automatic set_config(input logic [SCALE_W-1:0] scale, input logic [MINR_W-1:0] min_r);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_RANGE_SCALE, DATA_W'(scale));
		write_reg(REG_MIN_RANGE, DATA_W'(min_r));
		scale_setting = scale;
		min_range_setting = min_r;
		@(negedge clk);
	endtask

	// Point driver: offers queued points after each one's gap, holding the word until taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			point_valid <= 1'b0;
		end else begin
			if (point_valid && point_ready)
				offering = 1'b0;
			if (!offering && pending_points.size() > 0) begin
				if (gap_waited < pending_points[0].gap) begin
					gap_waited++;
				end else if (!pending_points[0].drain_first ||
						(points_taken == pixels_taken && !(point_valid && point_ready))) begin
					next_point = pending_points.pop_front();
					coord_x         <= next_point.x;
					coord_y         <= next_point.y;
					coord_z         <= next_point.z;
					return_strength <= next_point.strength;
					ambient_level   <= next_point.ambient;
					offering = 1'b1;
					gap_waited = 0;
				end
			end
			point_valid <= offering;
		end
	end

	// Pixel receiver: random stalls per word, calm stretches, and a long hold on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			pixel_ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
			pixel_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pixel_ready <= (hold_left == 0);
		end else if (pixel_valid && pixel_ready) begin
			if (rx_calm_left > 0) begin
				rx_calm_left--;
				rx_wait = 0;
			end else begin
				rx_wait = $urandom_range(0, 4);
				if ($urandom_range(0, 49) == 0)
					rx_calm_left = $urandom_range(20, 60);
			end
			pixel_ready <= (rx_wait == 0);
		end else if (!pixel_ready) begin
			if (rx_wait > 0)
				rx_wait--;
			pixel_ready <= (rx_wait == 0);
		end
	end

	// Monitor: checks each pixel word taken, then records the prediction for each point taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && pixel_ready) begin
				observed_pixel = pix_word_t'{range_pixel, strength_pixel, ambient_pixel, point_kept,
					kept_x, kept_y, kept_z, kept_strength};
				if (predicted_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected pixel word: %s", pixel_text(observed_pixel));
				end else begin
					check_pixel(predicted_pixels.pop_front(), observed_pixel);
				end
				pixels_taken <= pixels_taken + 1;
			end
			if (point_valid && point_ready) begin
				predicted_pixels.push_back(project_point(coord_x, coord_y, coord_z,
					return_strength, ambient_level, scale_setting, min_range_setting));
				points_taken <= points_taken + 1;
			end
		end
	end

	task automatic check_pixel(input pix_word_t want, input pix_word_t got);
		string bad;
		bad = "";
		if (got.range_pixel !== want.range_pixel)       bad = {bad, " range_pixel"};
		if (got.strength_pixel !== want.strength_pixel) bad = {bad, " strength_pixel"};
		if (got.ambient_pixel !== want.ambient_pixel)   bad = {bad, " ambient_pixel"};
		if (got.point_kept !== want.point_kept)         bad = {bad, " point_kept"};
		if (got.kept_x !== want.kept_x)                 bad = {bad, " kept_x"};
		if (got.kept_y !== want.kept_y)                 bad = {bad, " kept_y"};
		if (got.kept_z !== want.kept_z)                 bad = {bad, " kept_z"};
		if (got.kept_strength !== want.kept_strength)   bad = {bad, " kept_strength"};
		if (bad != "") begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Pixel word %0d differs in%s", pixels_taken, bad);
				$display("  expected %s", pixel_text(want));
				$display("  actual   %s", pixel_text(got));
			end
		end
	endtask

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus: directed points under reset settings, then random phases over several settings.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The receiver holds off early on so that the pipe and skid buffer fill.
		hold_requests = hold_requests + 1;

		// Origin, the minimum-range boundary and simple exact roots.
		add_point(24'sd0, 24'sd0, 24'sd0, 16'd0, 8'd0, 1'b0);
		add_point(24'sd102, 24'sd0, 24'sd0, 16'd1, 8'd1, 1'b0);
		add_point(24'sd101, 24'sd0, 24'sd0, 16'd255, 8'd254, 1'b0);
		add_point(24'sd0, -24'sd102, 24'sd0, 16'd256, 8'd128, 1'b0);
		add_point(24'sd0, 24'sd3, -24'sd4, 16'd100, 8'd7, 1'b0);
		add_point(24'sd1, 24'sd1, 24'sd1, 16'd65535, 8'd255, 1'b0);
		// Range of one metre, and the pixel just below and at saturation.
		add_point(24'sd1024, 24'sd0, 24'sd0, 16'd42, 8'd42, 1'b0);
		add_point(24'sd13055, 24'sd0, 24'sd0, 16'd254, 8'd3, 1'b0);
		add_point(24'sd0, 24'sd13056, 24'sd0, 16'd300, 8'd4, 1'b0);
		add_point(24'sd0, 24'sd0, 24'sd13107, 16'd1000, 8'd5, 1'b0);
		// Most negative and most positive coordinates.
		add_point(24'h800000, 24'h800000, 24'h800000, 16'hFFFF, 8'hFF, 1'b0);
		add_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h00FF, 8'h00, 1'b0);
		add_point(24'h800000, 24'sd0, 24'h7FFFFF, 16'h8000, 8'h80, 1'b0);
		// Alternating bit patterns so every payload bit toggles.
		add_point(24'h555555, 24'hAAAAAA, 24'h555555, 16'h5555, 8'h55, 1'b0);
		add_point(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 16'hAAAA, 8'hAA, 1'b0);
		add_point(-24'sd1, -24'sd1, -24'sd1, 16'h0100, 8'h01, 1'b0);
		add_random_points(PHASE_ITEMS, 150);

		// Zero scale and zero minimum: the origin is kept and every range pixel is zero.
		set_config(8'd0, 23'd0);
		add_point(24'sd0, 24'sd0, 24'sd0, 16'd17, 8'd9, 1'b0);
		add_random_points(PHASE_ITEMS, -1);

		// Largest scale and largest minimum.
		set_config(8'd255, 23'h7FFFFF);
		add_random_points(PHASE_ITEMS, -1);

		// Largest scale with every point kept.
		set_config(8'd255, 23'd0);
		add_random_points(PHASE_ITEMS, 100);

		// A few random settings with minima spread over the range magnitudes.
		for (int ph = 0; ph < 2; ph++) begin
			set_config(SCALE_W'($urandom_range(1, 254)),
				MINR_W'($urandom & ((32'd1 << $urandom_range(4, MINR_W)) - 1)));
			add_random_points(PHASE_ITEMS, -1);
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && predicted_pixels.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
